// ===== rtl/core/whbs_pkg.sv =====
// whbs_pkg: shared types and constants of the wrapped heightmap bilinear sampler
// no dependencies; imported by whbs_req_if and every rtl/core module
package whbs_pkg;

   localparam int GRID_BITS      = 5;
   localparam int GRID_SIDE      = 2 ** GRID_BITS;
   localparam int INDEX_BITS     = 2 * GRID_BITS;
   localparam int BANK_ADDR_BITS = 2 * (GRID_BITS - 1);

   localparam int COORD_BITS  = 32;
   localparam int OFFSET_BITS = COORD_BITS + 1;
   localparam int CELL_SHIFT  = 12;
   localparam int U_BITS      = OFFSET_BITS - CELL_SHIFT + 1;
   localparam int LOW_BITS    = CELL_SHIFT;
   localparam int FRAC_BITS   = 16;

   // cell is 3 * 4096 units; bias keeps the shifted offset positive and is a multiple of 96
   localparam logic [U_BITS-1:0] U_BIAS      = U_BITS'(3 * (2 ** 20));
   localparam logic [U_BITS-1:0] QUOT_RECIP  = U_BITS'(2796203);
   localparam int                QUOT_SHIFT  = 23;
   localparam int                NUMER_BITS  = 2 + LOW_BITS + 4;
   localparam logic [NUMER_BITS-1:0] FRAC_RECIP = NUMER_BITS'(174763);
   localparam int                FRAC_SHIFT  = 19;

   localparam int CSR_INDEX_BITS = 1;
   localparam int CSR_DATA_BITS  = 32;

   typedef enum logic {
      OP_WRITE  = 1'b0,
      OP_SAMPLE = 1'b1
   } op_type;

   typedef enum logic [CSR_INDEX_BITS-1:0] {
      CSR_ORG_X = 1'b0,
      CSR_ORG_Z = 1'b1
   } csr_reg_type;

   typedef struct packed {
      logic s1;
      logic s2;
      logic s3;
      logic s4;
      logic s5;
      logic s6;
   } stage_en_type;

endpackage

// ===== rtl/core/whbs_ifs.sv =====
// request and response channel interfaces of the heightmap sampler
// depends on whbs_pkg for field widths
interface whbs_req_if import whbs_pkg::*; #(parameter int HEIGHT_BITS = 24);
   logic                         valid;
   logic                         ready;
   logic                         opcode;
   logic [INDEX_BITS-1:0]        entry_index;
   logic signed [HEIGHT_BITS-1:0] entry_height;
   logic signed [COORD_BITS-1:0] point_x;
   logic signed [COORD_BITS-1:0] point_z;

   modport source (output valid, opcode, entry_index, entry_height, point_x, point_z,
                   input ready);
   modport sink   (input valid, opcode, entry_index, entry_height, point_x, point_z,
                   output ready);
endinterface

interface whbs_rsp_if #(parameter int HEIGHT_BITS = 24);
   logic                          valid;
   logic                          ready;
   logic signed [HEIGHT_BITS-1:0] height_out;

   modport source (output valid, height_out, input ready);
   modport sink   (input valid, height_out, output ready);
endinterface

// ===== rtl/core/wrapped_heightmap_bilinear_sampler.sv =====
// wrapped_heightmap_bilinear_sampler: top level, pipeline control, origin registers
// depends on whbs_pkg, whbs_ifs, whbs_split, whbs_table, whbs_blend
//
// req_ch carries write beats (opcode write: entry_index, entry_height) and sample
// beats (opcode sample: point_x, point_z). rsp_ch returns one height_out beat per
// sample beat, in order; write beats return nothing. csr_wr_en with csr_index and
// csr_wr_data sets the x or z grid origin; the user must write it only while the
// block is idle, which the block itself does not enforce. six register stages:
// offset, divide by cell, fraction and table read, x blend, z partial products,
// round into the output register. one beat per cycle sustained while rsp_ch.ready
// stays high; each stage takes a new beat whenever it is empty or its own beat
// moves on, so bubbles close up under a stall and ready falls only when all
// stages are full and rsp_ch.ready is low. the table is written in stage 3, in
// beat order with the reads, so a sample sees every earlier write.
// reset clears the valid bits and both origins; table contents stay undefined
// until written.
module wrapped_heightmap_bilinear_sampler import whbs_pkg::*; #(
   parameter int HEIGHT_BITS = 24
) (
   input  logic                      clock,
   input  logic                      reset,
   whbs_req_if.sink                  req_ch,
   whbs_rsp_if.source                rsp_ch,
   input  logic                      csr_wr_en,
   input  logic [CSR_INDEX_BITS-1:0] csr_index,
   input  logic [CSR_DATA_BITS-1:0]  csr_wr_data
);

   stage_en_type                  en;
   logic                          v1_ff, v2_ff, v3_ff, v4_ff, v5_ff, v6_ff;
   logic                          v1_in, v2_in, v3_in, v4_in, v5_in, v6_in;
   op_type                        op1_ff, op2_ff;
   logic [INDEX_BITS-1:0]         idx1_ff, idx2_ff;
   logic signed [HEIGHT_BITS-1:0] hgt1_ff, hgt2_ff;
   logic signed [COORD_BITS-1:0]  org_x_ff, org_z_ff;
   logic [GRID_BITS-1:0]          cell_x, cell_z;
   logic [FRAC_BITS-1:0]          frac_x, frac_z;
   logic signed [HEIGHT_BITS-1:0] h00, h10, h01, h11;
   logic                          tbl_wr;

   assign en.s6 = !v6_ff || rsp_ch.ready;
   assign en.s5 = !v5_ff || en.s6;
   assign en.s4 = !v4_ff || en.s5;
   assign en.s3 = !v3_ff || en.s4;
   assign en.s2 = !v2_ff || en.s3;
   assign en.s1 = !v1_ff || en.s2;

   assign req_ch.ready = en.s1;
   assign tbl_wr       = en.s3 && v2_ff && (op2_ff == OP_WRITE);

   always_comb begin
      v1_in = en.s1 ? req_ch.valid : v1_ff;
      v2_in = en.s2 ? v1_ff : v2_ff;
      v3_in = en.s3 ? (v2_ff && op2_ff == OP_SAMPLE) : v3_ff;
      v4_in = en.s4 ? v3_ff : v4_ff;
      v5_in = en.s5 ? v4_ff : v5_ff;
      v6_in = en.s6 ? v5_ff : v6_ff;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         v1_ff <= 1'b0;
         v2_ff <= 1'b0;
         v3_ff <= 1'b0;
         v4_ff <= 1'b0;
         v5_ff <= 1'b0;
         v6_ff <= 1'b0;
      end else begin
         v1_ff <= v1_in;
         v2_ff <= v2_in;
         v3_ff <= v3_in;
         v4_ff <= v4_in;
         v5_ff <= v5_in;
         v6_ff <= v6_in;
      end
   end

   always_ff @(posedge clock) begin
      if (en.s1) begin
         op1_ff  <= op_type'(req_ch.opcode);
         idx1_ff <= req_ch.entry_index;
         hgt1_ff <= req_ch.entry_height;
      end
      if (en.s2) begin
         op2_ff  <= op1_ff;
         idx2_ff <= idx1_ff;
         hgt2_ff <= hgt1_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         org_x_ff <= '0;
         org_z_ff <= '0;
      end else if (csr_wr_en) begin
         case (csr_reg_type'(csr_index))
            CSR_ORG_X: org_x_ff <= csr_wr_data;
            CSR_ORG_Z: org_z_ff <= csr_wr_data;
            default: ;
         endcase
      end
   end

   whbs_split u_split_x (
      .clock    (clock),
      .en       (en),
      .point    (req_ch.point_x),
      .origin   (org_x_ff),
      .grid_idx (cell_x),
      .frac     (frac_x)
   );

   whbs_split u_split_z (
      .clock    (clock),
      .en       (en),
      .point    (req_ch.point_z),
      .origin   (org_z_ff),
      .grid_idx (cell_z),
      .frac     (frac_z)
   );

   whbs_table #(.HEIGHT_BITS(HEIGHT_BITS)) u_table (
      .clock     (clock),
      .rd_en     (en.s3),
      .wr_en     (tbl_wr),
      .wr_index  (idx2_ff),
      .wr_height (hgt2_ff),
      .cell_x    (cell_x),
      .cell_z    (cell_z),
      .h00       (h00),
      .h10       (h10),
      .h01       (h01),
      .h11       (h11)
   );

   whbs_blend #(.HEIGHT_BITS(HEIGHT_BITS)) u_blend (
      .clock  (clock),
      .en     (en),
      .h00    (h00),
      .h10    (h10),
      .h01    (h01),
      .h11    (h11),
      .frac_x (frac_x),
      .frac_z (frac_z),
      .height (rsp_ch.height_out)
   );

   assign rsp_ch.valid = v6_ff;

   a_reset_empties: assert property (@(posedge clock)
      reset |=> !rsp_ch.valid)
      else $error("result valid right after reset");

   a_write_no_result: assert property (@(posedge clock) disable iff (reset)
      tbl_wr |=> !v3_ff)
      else $error("write beat reached the blend stages");

   a_stalled_holds: assert property (@(posedge clock) disable iff (reset)
      (v4_ff && !en.s4) |=> v4_ff)
      else $error("stalled x blend stage lost its beat");

   a_beat_reaches_out: assert property (@(posedge clock) disable iff (reset)
      (v5_ff && en.s6) |=> rsp_ch.valid)
      else $error("beat leaving stage 5 did not reach the output");

endmodule

// ===== rtl/core/whbs_split.sv =====
// whbs_split: one axis, origin subtract, floor divide by the cell, wrap and q16 fraction
// three register stages; depends on whbs_pkg
module whbs_split import whbs_pkg::*; (
   input  logic                         clock,
   input  stage_en_type                 en,
   input  logic signed [COORD_BITS-1:0] point,
   input  logic signed [COORD_BITS-1:0] origin,
   output logic [GRID_BITS-1:0]         grid_idx,
   output logic [FRAC_BITS-1:0]         frac
);

   logic [OFFSET_BITS-1:0]   offset;
   logic [U_BITS-1:0]        biased_in, biased_ff;
   logic [LOW_BITS-1:0]      low1_ff, low2_ff;
   logic [2*U_BITS-1:0]      quot_prod;
   logic [GRID_BITS-1:0]     cell_in, cell_ff;
   logic [1:0]               rem_in, rem_ff;
   logic [NUMER_BITS-1:0]    numer;
   logic [2*NUMER_BITS-1:0]  frac_prod;
   logic [FRAC_BITS-1:0]     frac_in, frac_ff;

   // stage 1: offset, arithmetic shift right by 12 (divide by 4096), bias positive
   assign offset    = {point[COORD_BITS-1], point} - {origin[COORD_BITS-1], origin};
   assign biased_in = {offset[OFFSET_BITS-1], offset[OFFSET_BITS-1:CELL_SHIFT]} + U_BIAS;

   // stage 2: divide by three, remainder from the low bits
   assign quot_prod = biased_ff * QUOT_RECIP;
   assign cell_in   = quot_prod[QUOT_SHIFT +: GRID_BITS];
   assign rem_in    = biased_ff[1:0] + quot_prod[QUOT_SHIFT +: 2];

   // stage 3: frac = floor((16 r + 1) / 3)
   assign numer     = {rem_ff, low2_ff, 4'b0001};
   assign frac_prod = numer * FRAC_RECIP;
   assign frac_in   = frac_prod[FRAC_SHIFT +: FRAC_BITS];

   always_ff @(posedge clock) begin
      if (en.s1) begin
         biased_ff <= biased_in;
         low1_ff   <= offset[LOW_BITS-1:0];
      end
      if (en.s2) begin
         cell_ff <= cell_in;
         rem_ff  <= rem_in;
         low2_ff <= low1_ff;
      end
      if (en.s3) begin
         frac_ff <= frac_in;
      end
   end

   assign grid_idx = cell_ff;
   assign frac     = frac_ff;

endmodule

// ===== rtl/core/whbs_table.sv =====
// whbs_table: height table in four banks by row and column parity, four corners per read
// registered read data; depends on whbs_pkg
module whbs_table import whbs_pkg::*; #(parameter int HEIGHT_BITS) (
   input  logic                          clock,
   input  logic                          rd_en,
   input  logic                          wr_en,
   input  logic [INDEX_BITS-1:0]         wr_index,
   input  logic signed [HEIGHT_BITS-1:0] wr_height,
   input  logic [GRID_BITS-1:0]          cell_x,
   input  logic [GRID_BITS-1:0]          cell_z,
   output logic signed [HEIGHT_BITS-1:0] h00,
   output logic signed [HEIGHT_BITS-1:0] h10,
   output logic signed [HEIGHT_BITS-1:0] h01,
   output logic signed [HEIGHT_BITS-1:0] h11
);

   localparam int BANK_DEPTH = 2 ** BANK_ADDR_BITS;

   logic [HEIGHT_BITS-1:0]    mem [4][BANK_DEPTH];
   logic [HEIGHT_BITS-1:0]    rd_data_ff [4];
   logic [BANK_ADDR_BITS-1:0] rd_addr [4];
   logic [BANK_ADDR_BITS-1:0] wr_addr;
   logic [1:0]                wr_bank;
   logic                      par_x_ff, par_z_ff;

   assign wr_addr = {wr_index[INDEX_BITS-1:GRID_BITS+1], wr_index[GRID_BITS-1:1]};
   assign wr_bank = {wr_index[GRID_BITS], wr_index[0]};

   // each bank holds the corner whose row and column parity match it
   always_comb begin
      logic [1:0]           bid;
      logic [GRID_BITS-1:0] row, col;
      for (int b = 0; b < 4; b++) begin
         bid = 2'(b);
         row = (cell_z[0] == bid[1]) ? cell_z : cell_z + 1'b1;
         col = (cell_x[0] == bid[0]) ? cell_x : cell_x + 1'b1;
         rd_addr[b] = {row[GRID_BITS-1:1], col[GRID_BITS-1:1]};
      end
   end

   always_ff @(posedge clock) begin
      if (rd_en) begin
         for (int b = 0; b < 4; b++) begin
            if (wr_en && wr_bank == 2'(b)) begin
               mem[b][wr_addr] <= wr_height;
            end
            rd_data_ff[b] <= mem[b][rd_addr[b]];
         end
         par_x_ff <= cell_x[0];
         par_z_ff <= cell_z[0];
      end
   end

   assign h00 = rd_data_ff[{par_z_ff, par_x_ff}];
   assign h10 = rd_data_ff[{par_z_ff, ~par_x_ff}];
   assign h01 = rd_data_ff[{~par_z_ff, par_x_ff}];
   assign h11 = rd_data_ff[{~par_z_ff, ~par_x_ff}];

endmodule

// ===== rtl/core/whbs_blend.sv =====
// whbs_blend: blend along x, then along z in split partial products, round to q.8
// three register stages; depends on whbs_pkg
module whbs_blend import whbs_pkg::*; #(parameter int HEIGHT_BITS) (
   input  logic                          clock,
   input  stage_en_type                  en,
   input  logic signed [HEIGHT_BITS-1:0] h00,
   input  logic signed [HEIGHT_BITS-1:0] h10,
   input  logic signed [HEIGHT_BITS-1:0] h01,
   input  logic signed [HEIGHT_BITS-1:0] h11,
   input  logic [FRAC_BITS-1:0]          frac_x,
   input  logic [FRAC_BITS-1:0]          frac_z,
   output logic signed [HEIGHT_BITS-1:0] height
);

   localparam int RW = HEIGHT_BITS + FRAC_BITS;
   localparam int DW = RW + 1;
   localparam int DL = DW / 2;
   localparam int DH = DW - DL;
   localparam int AW = RW + FRAC_BITS;
   localparam logic [AW-1:0] ROUND_HALF = {{(AW-32){1'b0}}, 1'b1, 31'b0};

   logic signed [HEIGHT_BITS:0]         dx0, dx1;
   logic signed [HEIGHT_BITS+FRAC_BITS+1:0] px0, px1;
   logic [RW-1:0]                       row0_in, row1_in, row0_ff, row1_ff, base_ff;
   logic [FRAC_BITS-1:0]                fz_ff;
   logic [DW-1:0]                       dz;
   logic [DL+FRAC_BITS-1:0]             plo_in, plo_ff;
   logic signed [DH+FRAC_BITS:0]        phi_in, phi_ff;
   logic [AW-1:0]                       sum;
   logic [HEIGHT_BITS-1:0]              height_ff;

   // stage 4: rows, h0 + (h1 - h0) * fx at 2^16 scale
   assign dx0     = {h10[HEIGHT_BITS-1], h10} - {h00[HEIGHT_BITS-1], h00};
   assign dx1     = {h11[HEIGHT_BITS-1], h11} - {h01[HEIGHT_BITS-1], h01};
   assign px0     = dx0 * $signed({1'b0, frac_x});
   assign px1     = dx1 * $signed({1'b0, frac_x});
   assign row0_in = {h00, {FRAC_BITS{1'b0}}} + px0[RW-1:0];
   assign row1_in = {h01, {FRAC_BITS{1'b0}}} + px1[RW-1:0];

   // stage 5: (row1 - row0) * fz as low and high partial products
   assign dz     = {row1_ff[RW-1], row1_ff} - {row0_ff[RW-1], row0_ff};
   assign plo_in = dz[DL-1:0] * fz_ff;
   assign phi_in = $signed(dz[DW-1:DL]) * $signed({1'b0, fz_ff});

   // stage 6: sum and round half up at bit 32
   assign sum = {base_ff, {FRAC_BITS{1'b0}}} + (AW'(phi_ff) << DL) + AW'(plo_ff) + ROUND_HALF;

   always_ff @(posedge clock) begin
      if (en.s4) begin
         row0_ff <= row0_in;
         row1_ff <= row1_in;
         fz_ff   <= frac_z;
      end
      if (en.s5) begin
         base_ff <= row0_ff;
         plo_ff  <= plo_in;
         phi_ff  <= phi_in;
      end
      if (en.s6) begin
         height_ff <= sum[AW-1:32];
      end
   end

   assign height = height_ff;

endmodule

// ===== tb/whbs_sample_checker.sv =====
`timescale 1ns / 100ps
// whbs_sample_checker: watches req, rsp and csr traffic of the heightmap sampler,
// keeps its own height table and origins, predicts each sample height and compares
// depends on whbs_pkg and the whbs_req_if / whbs_rsp_if interfaces
module whbs_sample_checker import whbs_pkg::*; #(
   parameter int HB = 24
) (
   input  logic                      clock,
   input  logic                      reset,
   whbs_req_if                       req_mon,
   whbs_rsp_if                       rsp_mon,
   input  logic                      csr_wr_en,
   input  logic [CSR_INDEX_BITS-1:0] csr_index,
   input  logic [CSR_DATA_BITS-1:0]  csr_wr_data,
   output int                        fail_count,
   output int                        pending_count
);

   localparam longint CELL_UNITS = 12288;
   localparam longint FRAC_ONE   = 65536;

   logic signed [HB-1:0]         height_store [GRID_SIDE*GRID_SIDE];
   logic signed [COORD_BITS-1:0] org_x_q;
   logic signed [COORD_BITS-1:0] org_z_q;
   logic signed [HB-1:0]         expected_heights [$];
   logic signed [HB-1:0]         want;

   // floor division by the cell, wrapped cell index, rounded q16 fraction
   function automatic void split_offset(input longint offset, output int grid_idx,
                                        output longint frac);
      longint q;
      longint r;
      q = offset / CELL_UNITS;
      r = offset % CELL_UNITS;
      if (r < 0) begin
         r += CELL_UNITS;
         q -= 1;
      end
      grid_idx = int'(q & longint'(GRID_SIDE - 1));
      frac = (2 * r * FRAC_ONE + CELL_UNITS) / (2 * CELL_UNITS);
   endfunction

   function automatic logic signed [HB-1:0] blend_height(
         input logic signed [COORD_BITS-1:0] px, input logic signed [COORD_BITS-1:0] pz);
      int     cx0, cz0, cx1, cz1;
      longint fx, fz, h00, h10, h01, h11, row0, row1, acc;
      split_offset(longint'(px) - longint'(org_x_q), cx0, fx);
      split_offset(longint'(pz) - longint'(org_z_q), cz0, fz);
      cx1  = (cx0 + 1) % GRID_SIDE;
      cz1  = (cz0 + 1) % GRID_SIDE;
      h00  = height_store[cz0 * GRID_SIDE + cx0];
      h10  = height_store[cz0 * GRID_SIDE + cx1];
      h01  = height_store[cz1 * GRID_SIDE + cx0];
      h11  = height_store[cz1 * GRID_SIDE + cx1];
      row0 = h00 * (FRAC_ONE - fx) + h10 * fx;
      row1 = h01 * (FRAC_ONE - fx) + h11 * fx;
      acc  = row0 * (FRAC_ONE - fz) + row1 * fz;
      // round half up from 2^32 scale down to q.8
      return HB'((acc + (longint'(1) <<< 31)) >>> 32);
   endfunction

   always @(posedge clock) begin
      if (reset) begin
         expected_heights.delete();
         org_x_q       = '0;
         org_z_q       = '0;
         fail_count    = 0;
         pending_count = 0;
      end else begin
         if (csr_wr_en) begin
            case (csr_reg_type'(csr_index))
               CSR_ORG_X: org_x_q = csr_wr_data;
               CSR_ORG_Z: org_z_q = csr_wr_data;
               default: ;
            endcase
         end
         if (req_mon.valid && req_mon.ready) begin
            if (op_type'(req_mon.opcode) == OP_WRITE)
               height_store[req_mon.entry_index] = req_mon.entry_height;
            else
               expected_heights.insert(expected_heights.size(),
                                       blend_height(req_mon.point_x, req_mon.point_z));
         end
         if (rsp_mon.valid && rsp_mon.ready) begin
            if (expected_heights.size() == 0) begin
               fail_count++;
               $display("%0t: height_out expected none, got %0d", $time,
                        rsp_mon.height_out);
            end else begin
               want = expected_heights.pop_front();
               if (rsp_mon.height_out !== want) begin
                  fail_count++;
                  $display("%0t: height_out expected %0d, got %0d", $time, want,
                           rsp_mon.height_out);
               end
            end
         end
         pending_count = expected_heights.size();
      end
   end

endmodule

// ===== tb/tb_top.sv =====
`timescale 1ns / 100ps
// tb_top: clock, reset and stimulus for wrapped_heightmap_bilinear_sampler, verdict at the end
// depends on whbs_pkg, the whbs interfaces, the rtl and tb/whbs_sample_checker.sv
module tb_top;
   import whbs_pkg::*;

   localparam int HB = 24;
   localparam logic signed [COORD_BITS-1:0] COORD_MAX = 32'sh7FFF_FFFF;
   localparam logic signed [COORD_BITS-1:0] COORD_MIN = 32'sh8000_0000;
   localparam logic signed [HB-1:0]         H_MAX     = {1'b0, {(HB-1){1'b1}}};
   localparam logic signed [HB-1:0]         H_MIN     = {1'b1, {(HB-1){1'b0}}};

   logic                      clock = 1'b0;
   logic                      reset = 1'b1;
   logic                      csr_wr_en = 1'b0;
   logic [CSR_INDEX_BITS-1:0] csr_index = '0;
   logic [CSR_DATA_BITS-1:0]  csr_wr_data = '0;
   int                        fail_count;
   int                        pending_count;
   bit                        gapless = 1'b0;
   bit                        long_hold_req = 1'b0;
   int                        burst_left = 0;
   logic signed [COORD_BITS-1:0] cur_base_x = '0;
   logic signed [COORD_BITS-1:0] cur_base_z = '0;

   whbs_req_if #(.HEIGHT_BITS(HB)) req_ch ();
   whbs_rsp_if #(.HEIGHT_BITS(HB)) rsp_ch ();

   wrapped_heightmap_bilinear_sampler #(.HEIGHT_BITS(HB)) uut (
      .clock       (clock),
      .reset       (reset),
      .req_ch      (req_ch),
      .rsp_ch      (rsp_ch),
      .csr_wr_en   (csr_wr_en),
      .csr_index   (csr_index),
      .csr_wr_data (csr_wr_data)
   );

   whbs_sample_checker #(.HB(HB)) u_checker (
      .clock         (clock),
      .reset         (reset),
      .req_mon       (req_ch),
      .rsp_mon       (rsp_ch),
      .csr_wr_en     (csr_wr_en),
      .csr_index     (csr_index),
      .csr_wr_data   (csr_wr_data),
      .fail_count    (fail_count),
      .pending_count (pending_count)
   );

   always #5 clock = ~clock;

   initial begin
      #5_000_000;
      $display("Mismatches found");
      $finish;
   end

   function automatic logic signed [HB-1:0] pick_height();
      case ($urandom_range(0, 9))
         0: return H_MAX;
         1: return H_MIN;
         2: return '0;
         default: return HB'($urandom);
      endcase
   endfunction

   // points near cell edges, at half cells, in nearby cells, at the extremes or anywhere
   function automatic logic signed [COORD_BITS-1:0] pick_coord(
         input logic signed [COORD_BITS-1:0] org);
      longint base;
      base = longint'(org) + (longint'($urandom_range(0, 80)) - 40) * 12288;
      case ($urandom_range(0, 7))
         0: return $urandom;
         1: return $urandom_range(0, 1) ? COORD_MAX : COORD_MIN;
         2: return COORD_BITS'(base + longint'($urandom_range(0, 2)));
         3: return COORD_BITS'(base - longint'($urandom_range(1, 2)));
         4: return COORD_BITS'(base + 6144);
         default: return COORD_BITS'(base + longint'($urandom_range(0, 12287)));
      endcase
   endfunction

   // drive one beat at a falling edge, return at a falling edge after acceptance and any gap
   task automatic send_beat(input op_type op, input logic [INDEX_BITS-1:0] idx,
                            input logic signed [HB-1:0] h,
                            input logic signed [COORD_BITS-1:0] x,
                            input logic signed [COORD_BITS-1:0] z);
      int gap;
      req_ch.valid        <= 1'b1;
      req_ch.opcode       <= op;
      req_ch.entry_index  <= idx;
      req_ch.entry_height <= h;
      req_ch.point_x      <= x;
      req_ch.point_z      <= z;
      do @(posedge clock); while (!req_ch.ready);
      @(negedge clock);
      if (!gapless) begin
         if (burst_left == 0) begin
            gap = ($urandom_range(0, 7) == 0) ? $urandom_range(8, 30) : $urandom_range(1, 4);
            req_ch.valid <= 1'b0;
            repeat (gap) @(negedge clock);
            burst_left = $urandom_range(1, 24);
         end else begin
            burst_left--;
         end
      end
   endtask

   task automatic write_origins(input logic signed [COORD_BITS-1:0] ox,
                                input logic signed [COORD_BITS-1:0] oz);
      req_ch.valid <= 1'b0;
      wait (pending_count == 0);
      @(negedge clock);
      repeat (12) @(negedge clock);
      csr_wr_en   <= 1'b1;
      csr_index   <= CSR_ORG_X;
      csr_wr_data <= ox;
      @(negedge clock);
      csr_index   <= CSR_ORG_Z;
      csr_wr_data <= oz;
      @(negedge clock);
      csr_wr_en   <= 1'b0;
      cur_base_x = ox;
      cur_base_z = oz;
   endtask

   task automatic run_random(input int count);
      int n;
      for (n = 0; n < count; n++) begin
         if (n % 64 == 0)
            gapless = ($urandom_range(0, 3) == 0);
         if ($urandom_range(0, 99) < 15)
            send_beat(OP_WRITE, INDEX_BITS'($urandom), pick_height(), $urandom, $urandom);
         else
            send_beat(OP_SAMPLE, INDEX_BITS'($urandom), HB'($urandom),
                      pick_coord(cur_base_x), pick_coord(cur_base_z));
      end
      gapless = 1'b0;
   endtask

   // receiver: ready pattern changes every stretch, with one long hold-off on request
   initial begin
      int mode;
      int span;
      logic [15:0] mask;
      bit hold_done;
      hold_done = 1'b0;
      rsp_ch.ready = 1'b0;
      forever begin
         mode = $urandom_range(0, 3);
         span = $urandom_range(20, 120);
         mask = 16'($urandom);
         for (int i = 0; i < span; i++) begin
            @(negedge clock);
            if (long_hold_req && !hold_done) begin
               rsp_ch.ready <= 1'b0;
               repeat (150) @(negedge clock);
               hold_done = 1'b1;
            end
            case (mode)
               0: rsp_ch.ready <= 1'b1;
               1: rsp_ch.ready <= 1'($urandom_range(0, 1));
               2: rsp_ch.ready <= mask[i % 16];
               default: rsp_ch.ready <= ($urandom_range(0, 7) != 0);
            endcase
         end
      end
   end

   initial begin
      req_ch.valid        = 1'b0;
      req_ch.opcode       = OP_WRITE;
      req_ch.entry_index  = '0;
      req_ch.entry_height = '0;
      req_ch.point_x      = '0;
      req_ch.point_z      = '0;
      repeat (6) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;
      @(negedge clock);

      write_origins('0, '0);
      // fill the whole table so no sample reads an unwritten entry
      for (int i = 0; i < GRID_SIDE * GRID_SIDE; i++)
         send_beat(OP_WRITE, INDEX_BITS'(i), pick_height(), $urandom, $urandom);

      // extreme heights around the origin cell and the wrap corner
      send_beat(OP_WRITE, INDEX_BITS'(0),    H_MAX, COORD_MAX, COORD_MIN);
      send_beat(OP_WRITE, INDEX_BITS'(1),    H_MIN, '0, '0);
      send_beat(OP_WRITE, INDEX_BITS'(32),   H_MIN, '1, '1);
      send_beat(OP_WRITE, INDEX_BITS'(33),   H_MAX, '0, '0);
      send_beat(OP_WRITE, INDEX_BITS'(31),   H_MIN, '0, '0);
      send_beat(OP_WRITE, INDEX_BITS'(992),  H_MIN, '0, '0);
      send_beat(OP_WRITE, INDEX_BITS'(1023), H_MAX, '0, '0);
      // on the grid point, half cells, just below the edge, negative offsets
      send_beat(OP_SAMPLE, '1, H_MAX, 0, 0);
      send_beat(OP_SAMPLE, '0, H_MIN, 6144, 6144);
      send_beat(OP_SAMPLE, '0, '0, 12287, 12287);
      send_beat(OP_SAMPLE, '0, '0, 1, 1);
      send_beat(OP_SAMPLE, '0, '0, -1, -1);
      send_beat(OP_SAMPLE, '0, '0, -12288, -6144);
      // wrap across the last cell, a full grid span and the coordinate extremes
      send_beat(OP_SAMPLE, '0, '0, 387072, 0);
      send_beat(OP_SAMPLE, '0, '0, 393216, 393216);
      send_beat(OP_SAMPLE, '0, '0, COORD_MAX, COORD_MIN);
      send_beat(OP_SAMPLE, '0, '0, COORD_MIN, COORD_MAX);

      run_random(120);
      // long receiver hold-off while samples keep coming back to back
      long_hold_req = 1'b1;
      gapless = 1'b1;
      for (int i = 0; i < 40; i++)
         send_beat(OP_SAMPLE, INDEX_BITS'($urandom), HB'($urandom),
                   pick_coord(cur_base_x), pick_coord(cur_base_z));
      gapless = 1'b0;
      run_random(120);

      write_origins(COORD_MIN, COORD_MAX);
      send_beat(OP_SAMPLE, '0, '0, COORD_MAX, COORD_MIN);
      send_beat(OP_SAMPLE, '0, '0, COORD_MIN, COORD_MAX);
      run_random(125);

      write_origins(COORD_MAX, COORD_MIN);
      send_beat(OP_SAMPLE, '0, '0, COORD_MIN, COORD_MAX);
      send_beat(OP_SAMPLE, '0, '0, COORD_MAX, COORD_MIN);
      run_random(125);

      write_origins($urandom, $urandom);
      run_random(125);

      req_ch.valid <= 1'b0;
      wait (pending_count == 0);
      repeat (20) @(negedge clock);
      if (fail_count == 0)
         $display("No mismatches found");
      else
         $display("Mismatches found");
      $finish;
   end

endmodule
